FILE: hw/rtl/guide_offtarget_hamming_scan_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the off-target scan unit
// Implication checks on the design clock, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef GUIDE_OFFTARGET_HAMMING_SCAN_UNIT_MACROS_SVH
`define GUIDE_OFFTARGET_HAMMING_SCAN_UNIT_MACROS_SVH

// same-cycle implication
`define GOHS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GOHS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gohs_pkg.sv
// ----------------------------------------------------------------------------
// gohs_pkg
// Shared widths, codes and beat types of the off-target scan unit.
// ----------------------------------------------------------------------------
package gohs_pkg;

    localparam int WORD_W        = 63;  // 2-bit bases plus orientation flag
    localparam int LEN_W         = 5;
    localparam int MAX_BASES     = 31;
    localparam int LIST_W        = 16;
    localparam int ID_W          = 32;
    localparam int MM_W          = 3;
    localparam int BIN_W         = 4;   // holds bin numbers up to 15
    localparam int MMC_W         = 6;   // raw mismatch count, 0..32
    localparam int CFG_IDX_W     = 2;
    localparam int CLASS_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY      = 2'd0,
        CFG_LEN        = 2'd1,
        CFG_MAX_LISTED = 2'd2
    } t_cfg_index;

    typedef enum logic {
        ST_RUN  = 1'b0,
        ST_HIST = 1'b1
    } t_back_state;

    // classified entry, front to back
    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
        logic             last;
    } t_class_item;

    // one result beat
    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] entry_id;
        logic [MM_W-1:0] mismatches;
        logic [ID_W-1:0] bin_count;
        logic            list_complete;
        logic            last;
    } t_record;

endpackage

FILE: hw/rtl/gohs_queue.sv
// ----------------------------------------------------------------------------
// gohs_queue
// Small register FIFO with occupancy count; caller never writes when full.
// ----------------------------------------------------------------------------
module gohs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;

endmodule

FILE: hw/rtl/gohs_front.sv
// ----------------------------------------------------------------------------
// gohs_front
// Accepts database words, orients them against the query, counts base
// mismatches and classifies each entry for the back end.
// ----------------------------------------------------------------------------
module gohs_front
    import gohs_pkg::*;
#(
    parameter int HIT_MM_MAX = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [WORD_W-1:0]                  i_entry_word,
    input  logic                               i_last_entry,
    input  logic [WORD_W-1:0]                  i_query,
    input  logic [LEN_W-1:0]                   i_len,
    input  logic [$clog2(CLASS_Q_DEPTH+1)-1:0] i_q_count,
    output logic                               o_full,
    output logic                               o_item_valid,
    output t_class_item                        o_item
);

    localparam int QC_W = $clog2(CLASS_Q_DEPTH+1);

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_diff;
    logic              r_s1_last;

    logic [WORD_W-1:0] w_rcq;
    logic [WORD_W-1:0] w_flag;
    logic [WORD_W-1:0] w_diff;
    logic              w_accept;
    logic [WORD_W:0]   w_dx;
    logic [31:0]       w_pairs;
    logic [MMC_W-1:0]  w_mm;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] s;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + {3'b000, v[k]};
        end
        return s;
    endfunction

    // stage 0: reverse complement of the query over the low 2*len bits
    always_comb begin
        w_rcq = i_query;
        for (int i = 0; i < MAX_BASES; i++) begin
            if (i < int'(i_len)) begin
                w_rcq[2*i +: 2] = ~i_query[2*(int'(i_len)-1-i) +: 2];
            end
        end
    end

    always_comb begin
        w_flag = WORD_W'(1) << {i_len, 1'b0};
        w_diff = i_query ^ i_entry_word;
        if (|(w_diff & w_flag)) begin
            w_diff = w_rcq ^ i_entry_word;
        end
        w_diff = w_diff & ~w_flag;
    end

    // in-flight stage entry reserves a queue slot
    assign o_full   = ({1'b0, i_q_count} + (QC_W+1)'(r_s1_valid)) >= (QC_W+1)'(CLASS_Q_DEPTH);
    assign w_accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_diff <= w_diff;
            r_s1_last <= i_last_entry;
        end
    end

    // stage 1: mismatching bases, tree of four 8-pair counts
    always_comb begin
        w_dx = {1'b0, r_s1_diff};
        for (int j = 0; j < 32; j++) begin
            w_pairs[j] = w_dx[2*j] | w_dx[2*j+1];
        end
        w_mm = {2'b00, popcount8(w_pairs[7:0])}   + {2'b00, popcount8(w_pairs[15:8])}
             + {2'b00, popcount8(w_pairs[23:16])} + {2'b00, popcount8(w_pairs[31:24])};
    end

    assign o_item_valid = r_s1_valid;
    assign o_item.hit   = (w_mm <= MMC_W'(HIT_MM_MAX));
    assign o_item.bin   = w_mm[BIN_W-1:0];
    assign o_item.last  = r_s1_last;

endmodule

FILE: hw/rtl/gohs_back.sv
// ----------------------------------------------------------------------------
// gohs_back
// Entry counter, match total and histogram; builds hit and histogram beats.
// ----------------------------------------------------------------------------
`include "guide_offtarget_hamming_scan_unit_macros.svh"

module gohs_back
    import gohs_pkg::*;
#(
    parameter int HIT_MM_MAX  = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LIST_W-1:0] i_max_listed,
    input  logic              i_item_valid,
    input  t_class_item       i_item,
    output logic              o_item_pop,
    input  logic              i_out_full,
    output logic              o_rec_valid,
    output t_record           o_rec
);

    localparam int CW = COUNT_WIDTH;

    t_back_state      r_state, n_state;
    logic [BIN_W-1:0] r_bin, n_bin;
    logic             r_complete, n_complete;
    logic [CW-1:0]    r_entry_cnt, n_entry_cnt;
    logic [CW-1:0]    r_total, n_total;
    logic [CW-1:0]    r_hist [HIT_MM_MAX+1];
    logic [CW-1:0]    n_hist [HIT_MM_MAX+1];

    logic             w_take;
    logic             w_emit;
    logic             w_hist_done;
    logic             w_hit_rec;
    logic [CW-1:0]    w_cnt_inc;
    logic [CW-1:0]    w_tot_inc;
    logic [CW-1:0]    w_limit;
    logic [CW+ID_W-1:0] w_id_ext;
    logic [CW+ID_W-1:0] w_bin_ext;
    logic [BIN_W+MM_W-1:0] w_bin_num;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    assign w_limit     = CW'(i_max_listed);
    assign w_take      = (r_state == ST_RUN) && i_item_valid && !i_out_full;
    assign w_emit      = (r_state == ST_HIST) && !i_out_full;
    assign w_hist_done = w_emit && (r_bin == BIN_W'(HIT_MM_MAX));
    assign w_cnt_inc   = r_entry_cnt + CW'(1);
    assign w_tot_inc   = sat_inc(r_total);
    assign w_hit_rec   = i_item.hit && (w_tot_inc < w_limit);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (w_take && i_item.last) begin
                    n_state = ST_HIST;
                end
            end
            ST_HIST: begin
                if (w_hist_done) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // counters and histogram
    always_comb begin
        n_bin       = r_bin;
        n_complete  = r_complete;
        n_entry_cnt = r_entry_cnt;
        n_total     = r_total;
        for (int b = 0; b <= HIT_MM_MAX; b++) begin
            n_hist[b] = r_hist[b];
        end
        if (w_take) begin
            n_entry_cnt = w_cnt_inc;
            if (i_item.hit) begin
                n_total = w_tot_inc;
                for (int b = 0; b <= HIT_MM_MAX; b++) begin
                    if (i_item.bin == BIN_W'(b)) begin
                        n_hist[b] = sat_inc(r_hist[b]);
                    end
                end
            end
            if (i_item.last) begin
                n_complete  = ((i_item.hit ? w_tot_inc : r_total) < w_limit);
                n_bin       = '0;
                n_entry_cnt = '0;
                n_total     = '0;
            end
        end
        // bins shift toward bin 0 as they go out; empty afterwards
        if (w_emit) begin
            n_bin = r_bin + BIN_W'(1);
            for (int b = 0; b < HIT_MM_MAX; b++) begin
                n_hist[b] = r_hist[b+1];
            end
            n_hist[HIT_MM_MAX] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_bin       <= '0;
            r_complete  <= 1'b0;
            r_entry_cnt <= '0;
            r_total     <= '0;
            for (int b = 0; b <= HIT_MM_MAX; b++) begin
                r_hist[b] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_bin       <= n_bin;
            r_complete  <= n_complete;
            r_entry_cnt <= n_entry_cnt;
            r_total     <= n_total;
            for (int b = 0; b <= HIT_MM_MAX; b++) begin
                r_hist[b] <= n_hist[b];
            end
        end
    end

    // beat build
    assign w_id_ext  = {{ID_W{1'b0}}, w_cnt_inc};
    assign w_bin_ext = {{ID_W{1'b0}}, r_hist[0]};
    assign w_bin_num = {{MM_W{1'b0}}, (w_emit ? r_bin : i_item.bin)};

    always_comb begin
        o_item_pop  = w_take;
        o_rec_valid = w_emit || (w_take && w_hit_rec);
        o_rec.mismatches = w_bin_num[MM_W-1:0];
        if (w_emit) begin
            o_rec.kind          = 1'b1;
            o_rec.entry_id      = '0;
            o_rec.bin_count     = w_bin_ext[ID_W-1:0];
            o_rec.list_complete = r_complete;
            o_rec.last          = (r_bin == BIN_W'(HIT_MM_MAX));
        end else begin
            o_rec.kind          = 1'b0;
            o_rec.entry_id      = w_id_ext[ID_W-1:0];
            o_rec.bin_count     = '0;
            o_rec.list_complete = 1'b0;
            o_rec.last          = 1'b0;
        end
    end

    `GOHS_ASSERT_IMP(a_no_pop_in_hist, i_clk, i_rst_n, r_state == ST_HIST, !o_item_pop, "entry taken during histogram dump")
    `GOHS_ASSERT_NXT(a_last_starts_hist, i_clk, i_rst_n, o_item_pop && i_item.last, r_state == ST_HIST && r_bin == '0, "last entry did not start histogram dump")
    `GOHS_ASSERT_NXT(a_counters_clear, i_clk, i_rst_n, w_hist_done, r_total == '0 && r_entry_cnt == '0 && r_hist[0] == '0, "counters not clear after dump")
    `GOHS_ASSERT_IMP(a_hit_has_entry, i_clk, i_rst_n, o_rec_valid && !o_rec.kind, w_take && i_item.hit, "hit beat without a matching entry")

endmodule

FILE: hw/rtl/guide_offtarget_hamming_scan_unit.sv
// ----------------------------------------------------------------------------
// guide_offtarget_hamming_scan_unit: 2-bit DNA Hamming off-target scan
// Path: a hit beat passes stage 1, the entry queue and the result FIFO.
// Rate: 1 entry per cycle unless stalled; a last entry adds HIT_MM_MAX+1 beats.
// Reset: synchronous active low; counters, histogram and queues cleared at once.
// ----------------------------------------------------------------------------
//
// Structure
//   front  : stage 0 orients the word (reverse complement when the flag bits
//            differ) and masks the flag; stage 1 counts mismatching base pairs
//            and classifies the entry (hit / bin / last).
//   queue  : short FIFO of classified entries; the front reserves a slot for
//            its in-flight stage, so full depends on registers only.
//   back   : entry counter, saturating match total and histogram bins, one
//            entry per cycle. After a last entry it dumps one histogram beat
//            per cycle, shifting the bins down, which leaves them cleared.
//   result : output FIFO; the back stalls only when it is full.
//
// The dump loop in the back end is what limits the rate after a last entry;
// otherwise one entry per cycle flows while the result side pops.
// Configuration port is always ready; a write to an unused index is dropped.
//
`include "guide_offtarget_hamming_scan_unit_macros.svh"

module guide_offtarget_hamming_scan_unit
    import gohs_pkg::*;
#(
    parameter int HIT_MM_MAX  = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // entry side
    input  logic                 push,
    output logic                 full,
    input  logic [WORD_W-1:0]    i_entry_word,
    input  logic                 i_last_entry,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_kind,
    output logic [ID_W-1:0]      o_entry_id,
    output logic [MM_W-1:0]      o_mismatches,
    output logic [ID_W-1:0]      o_bin_count,
    output logic                 o_list_complete,
    output logic                 o_last,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int CQ_W = $clog2(CLASS_Q_DEPTH+1);
    localparam int OQ_W = $clog2(OUT_Q_DEPTH+1);

    // configuration registers
    logic [WORD_W-1:0] r_query;
    logic [LEN_W-1:0]  r_len;
    logic [LIST_W-1:0] r_max_listed;

    // front to queue
    logic              w_item_valid;
    t_class_item       w_item;
    // queue to back
    logic [$bits(t_class_item)-1:0] w_cq_data;
    logic              w_cq_empty;
    logic              w_cq_full;
    logic [CQ_W-1:0]   w_cq_count;
    logic              w_item_pop;
    // back to result FIFO
    logic              w_rec_valid;
    t_record           w_rec;
    logic [$bits(t_record)-1:0] w_oq_data;
    logic              w_oq_full;
    logic [OQ_W-1:0]   w_oq_count;
    t_record           w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query      <= '0;
            r_len        <= LEN_W'(20);
            r_max_listed <= LIST_W'(2000);
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_QUERY:      r_query      <= i_cfg_data;
                CFG_LEN:        r_len        <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_LISTED: r_max_listed <= i_cfg_data[LIST_W-1:0];
                default:        ;
            endcase
        end
    end

    gohs_front #(
        .HIT_MM_MAX (HIT_MM_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry_word (i_entry_word),
        .i_last_entry (i_last_entry),
        .i_query      (r_query),
        .i_len        (r_len),
        .i_q_count    (w_cq_count),
        .o_full       (full),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    gohs_queue #(
        .WIDTH ($bits(t_class_item)),
        .DEPTH (CLASS_Q_DEPTH)
    ) u_class_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_item_valid),
        .i_data  (w_item),
        .i_rd    (w_item_pop),
        .o_data  (w_cq_data),
        .o_empty (w_cq_empty),
        .o_full  (w_cq_full),
        .o_count (w_cq_count)
    );

    gohs_back #(
        .HIT_MM_MAX  (HIT_MM_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_listed (r_max_listed),
        .i_item_valid (!w_cq_empty),
        .i_item       (t_class_item'(w_cq_data)),
        .o_item_pop   (w_item_pop),
        .i_out_full   (w_oq_full),
        .o_rec_valid  (w_rec_valid),
        .o_rec        (w_rec)
    );

    gohs_queue #(
        .WIDTH ($bits(t_record)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_rec_valid),
        .i_data  (w_rec),
        .i_rd    (pop && !empty),
        .o_data  (w_oq_data),
        .o_empty (empty),
        .o_full  (w_oq_full),
        .o_count (w_oq_count)
    );

    assign w_head          = t_record'(w_oq_data);
    assign o_kind          = w_head.kind;
    assign o_entry_id      = w_head.entry_id;
    assign o_mismatches    = w_head.mismatches;
    assign o_bin_count     = w_head.bin_count;
    assign o_list_complete = w_head.list_complete;
    assign o_last          = w_head.last;

    `GOHS_ASSERT_IMP(a_class_q_room, i_clk, i_rst_n, w_item_valid, !w_cq_full || w_item_pop, "classified entry pushed into a full queue")
    `GOHS_ASSERT_IMP(a_out_q_room, i_clk, i_rst_n, w_rec_valid, w_oq_count != OQ_W'(OUT_Q_DEPTH), "result beat written into a full FIFO")
    `GOHS_ASSERT_NXT(a_accept_in_flight, i_clk, i_rst_n, push && !full, w_item_valid, "accepted entry missing from front stage")

endmodule

FILE: bench/guide_offtarget_hamming_scan_checker.sv
// ----------------------------------------------------------------------------
// guide_offtarget_hamming_scan_checker: result checker for the scan unit
// Watches the entry, result and configuration channels, predicts every
// hit and histogram beat, and compares result beats field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module guide_offtarget_hamming_scan_checker
    import gohs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // entry side
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [WORD_W-1:0]    i_entry_word,
    input  logic                 i_last_entry,
    // result side
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic                 i_kind,
    input  logic [ID_W-1:0]      i_entry_id,
    input  logic [MM_W-1:0]      i_mismatches,
    input  logic [ID_W-1:0]      i_bin_count,
    input  logic                 i_list_complete,
    input  logic                 i_last,
    // configuration writes
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // status to the bench top
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int              TOP_BIN      = 4;
    localparam logic            KIND_HIT     = 1'b0;
    localparam logic            KIND_HIST    = 1'b1;
    localparam logic [ID_W-1:0] COUNT_MAX    = '1;
    localparam int              REPORT_LIMIT = 10;

    // mirrored registers
    logic [WORD_W-1:0] query_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LIST_W-1:0] list_limit;

    // scan counters
    logic [ID_W-1:0] entry_count;
    logic [ID_W-1:0] match_count;
    logic [ID_W-1:0] mm_bins [0:TOP_BIN];

    t_record expected_records[$];

    // reverse complement of the low len bases; bits above them kept
    function automatic logic [63:0] revcomp_bases(input logic [63:0] w, input int len);
        logic [63:0] keep_mask;
        logic [63:0] rc;
        int          i;
        keep_mask = (len == 0) ? '1 : ~((64'd1 << (2 * len)) - 64'd1);
        rc = '0;
        for (i = 0; i < len; i++) begin
            rc[2*i +: 2] = ~w[2*(len-1-i) +: 2];
        end
        return (w & keep_mask) | rc;
    endfunction

    // number of 2-bit pairs with any bit set
    function automatic int count_base_mismatches(input logic [63:0] x);
        logic [63:0] pairs;
        int          n;
        int          i;
        pairs = (x | (x >> 1)) & 64'h5555_5555_5555_5555;
        n = 0;
        for (i = 0; i < 32; i++) begin
            n += int'(pairs[2*i]);
        end
        return n;
    endfunction

    function automatic logic [ID_W-1:0] sat_bump(input logic [ID_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic predict_entry(input logic [WORD_W-1:0] word, input logic last_entry);
        logic [63:0] flag;
        logic [63:0] diff;
        int          mm;
        logic        complete;
        t_record     rec;
        int          b;
        flag = 64'd1 << (2 * int'(len_reg));
        diff = {1'b0, query_reg} ^ {1'b0, word};
        entry_count = entry_count + 1'b1;
        if ((diff & flag) != 0) begin
            diff = revcomp_bases({1'b0, query_reg}, int'(len_reg)) ^ {1'b0, word};
        end
        mm = count_base_mismatches(diff & ~flag);
        if (mm <= TOP_BIN) begin
            mm_bins[mm] = sat_bump(mm_bins[mm]);
            match_count = sat_bump(match_count);
            if (match_count < ID_W'(list_limit)) begin
                rec = '0;
                rec.kind       = KIND_HIT;
                rec.entry_id   = entry_count;
                rec.mismatches = MM_W'(mm);
                expected_records = {expected_records, rec};
            end
        end
        if (last_entry) begin
            complete = (match_count < ID_W'(list_limit));
            for (b = 0; b <= TOP_BIN; b++) begin
                rec = '0;
                rec.kind          = KIND_HIST;
                rec.mismatches    = MM_W'(b);
                rec.bin_count     = mm_bins[b];
                rec.list_complete = complete;
                rec.last          = (b == TOP_BIN);
                expected_records = {expected_records, rec};
                mm_bins[b] = '0;
            end
            entry_count = '0;
            match_count = '0;
        end
    endtask

    task automatic report_field(input string name, input logic [ID_W-1:0] want,
                                input logic [ID_W-1:0] got);
        if (want !== got) begin
            if (o_fail_count < REPORT_LIMIT) begin
                $display("%0t: result %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
            end
            o_fail_count++;
        end
    endtask

    task automatic check_beat();
        t_record want;
        if (expected_records.size() == 0) begin
            if (o_fail_count < REPORT_LIMIT) begin
                $display("%0t: result beat with none expected (kind %0d id %0d)",
                         $time, i_kind, i_entry_id);
            end
            o_fail_count++;
        end else begin
            want = expected_records.pop_front();
            report_field("kind", want.kind, i_kind);
            report_field("entry_id", want.entry_id, i_entry_id);
            report_field("mismatches", want.mismatches, i_mismatches);
            report_field("bin_count", want.bin_count, i_bin_count);
            report_field("list_complete", want.list_complete, i_list_complete);
            report_field("last", want.last, i_last);
        end
    endtask

    always @(posedge i_clk) begin : watch
        int b;
        if (!i_rst_n) begin
            query_reg    = '0;
            len_reg      = LEN_W'(20);
            list_limit   = LIST_W'(2000);
            entry_count  = '0;
            match_count  = '0;
            for (b = 0; b <= TOP_BIN; b++) begin
                mm_bins[b] = '0;
            end
            expected_records.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUERY:      query_reg  = i_cfg_data;
                    CFG_LEN:        len_reg    = i_cfg_data[LEN_W-1:0];
                    CFG_MAX_LISTED: list_limit = i_cfg_data[LIST_W-1:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                check_beat();
            end
            if (i_push && !i_full) begin
                predict_entry(i_entry_word, i_last_entry);
            end
        end
        o_pending = expected_records.size();
    end

endmodule

FILE: bench/guide_offtarget_hamming_scan_unit_test.sv
// ----------------------------------------------------------------------------
// guide_offtarget_hamming_scan_unit_test: bench top for the off-target scan
// Drives database entries and register writes, pops result beats with random
// stalls, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module guide_offtarget_hamming_scan_unit_test;
    import gohs_pkg::*;

    // index with no register behind it; writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // covers the hit path and the 5 dump beats of a last entry; round up
    localparam int          DRAIN_CYCLES = 12;
    localparam int          RANDOM_ITEMS = 400;
    localparam logic [63:0] WORD_MASK64  = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [WORD_W-1:0]    i_entry_word;
    logic                 i_last_entry;
    logic                 empty;
    logic                 pop;
    logic                 o_kind;
    logic [ID_W-1:0]      o_entry_id;
    logic [MM_W-1:0]      o_mismatches;
    logic [ID_W-1:0]      o_bin_count;
    logic                 o_list_complete;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    int pending_results;
    int fail_count;

    // what the stimulus believes is loaded; starts at the reset values
    logic [WORD_W-1:0] cur_query = '0;
    int                cur_len   = 20;

    int tx_burst     = 0;   // beats left to push back to back
    int rx_burst     = 0;   // beats left to pop without stalling
    int random_sent  = 0;

    guide_offtarget_hamming_scan_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_entry_word   (i_entry_word),
        .i_last_entry   (i_last_entry),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_entry_id     (o_entry_id),
        .o_mismatches   (o_mismatches),
        .o_bin_count    (o_bin_count),
        .o_list_complete(o_list_complete),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    guide_offtarget_hamming_scan_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_entry_word   (i_entry_word),
        .i_last_entry   (i_last_entry),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (o_kind),
        .i_entry_id     (o_entry_id),
        .i_mismatches   (o_mismatches),
        .i_bin_count    (o_bin_count),
        .i_list_complete(o_list_complete),
        .i_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_results),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("guide_offtarget_hamming_scan_unit_test: errors");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[WORD_W-1:0];
    endfunction

    // opposite-strand copy of a word: low len bases reversed and complemented
    function automatic logic [63:0] strand_flip(input logic [63:0] w, input int len);
        logic [63:0] out;
        int          i;
        out = w;
        for (i = 0; i < len; i++) begin
            out[2*i +: 2] = ~w[2*(len-1-i) +: 2];
        end
        return out;
    endfunction

    // Word that differs from the loaded query in min(k, len) distinct bases. flip puts
    // it on the other strand (flag toggled, compared against the reverse
    // complement); high_noise scrambles the bits above the flag.
    function automatic logic [WORD_W-1:0] near_word(input int k, input bit flip,
                                                     input bit high_noise);
        logic [63:0] w;
        logic [63:0] upper_mask;
        logic [31:0] used;
        int          kk;
        int          placed;
        int          p;
        w = {1'b0, cur_query};
        if (flip) begin
            w = strand_flip(w, cur_len) ^ (64'd1 << (2 * cur_len));
        end
        kk     = (k > cur_len) ? cur_len : k;
        used   = '0;
        placed = 0;
        while (placed < kk) begin
            p = $urandom_range(0, cur_len - 1);
            if (!used[p]) begin
                used[p] = 1'b1;
                w ^= 64'($urandom_range(1, 3)) << (2 * p);
                placed++;
            end
        end
        if (high_noise) begin
            upper_mask = WORD_MASK64 & ~((64'd2 << (2 * cur_len)) - 64'd1);
            w ^= {$urandom, $urandom} & upper_mask;
        end
        return w[WORD_W-1:0];
    endfunction

    // One entry beat. Leaves push high so the next call can follow back to
    // back; whoever stops sending must drop push at the same falling edge.
    task automatic send_entry(input logic [WORD_W-1:0] word, input logic last_entry);
        int gap;
        if (tx_burst > 0) begin
            tx_burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0) tx_burst = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_entry_word <= word;
        i_last_entry <= last_entry;
        push         <= 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every predicted beat to come out
    task automatic wait_drain();
        push <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    // valid stays high across a run of writes; the caller drops it
    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Registers change only with the unit idle: drained, then a few more
    // cycles for entries that made no beat but may still be in the pipe.
    // Upper data bits are random to check that the unit masks them.
    task automatic load_config(input logic [WORD_W-1:0] q, input int len, input int maxl);
        logic [WORD_W-1:0] d;
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_beat(CFG_QUERY, q);
        d = rand_word();
        d[LEN_W-1:0] = LEN_W'(len);
        cfg_beat(CFG_LEN, d);
        d = rand_word();
        d[LIST_W-1:0] = LIST_W'(maxl);
        cfg_beat(CFG_MAX_LISTED, d);
        cfg_beat(CFG_UNUSED, rand_word());
        i_cfg_valid <= 1'b0;
        cur_query = q;
        cur_len   = len;
    endtask

    // one scan: mostly near matches on either strand, some raw noise
    task automatic run_scan(input int entries);
        logic [WORD_W-1:0] w;
        int                i;
        for (i = 0; i < entries; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                w = near_word($urandom_range(0, 6), $urandom_range(0, 1),
                              $urandom_range(0, 7) == 0);
            end else begin
                w = rand_word();
            end
            send_entry(w, i == entries - 1);
            random_sent++;
        end
    endtask

    // result side: random stall before each beat, with stall-free stretches
    initial begin : result_drain
        int stall;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_burst > 0) begin
                rx_burst--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
                if ($urandom_range(0, 19) == 0) rx_burst = $urandom_range(8, 30);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int                phase;
        int                scans;
        int                s;
        int                len;
        int                maxl;
        logic [WORD_W-1:0] q;

        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_entry_word = '0;
        i_last_entry = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_QUERY;
        i_cfg_data   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed: reset registers (query 0, 20 bases, limit 2000) ---
        send_entry('0, 1'b0);                 // exact match, id 1
        send_entry('1, 1'b0);                 // other strand, bits above flag set
        send_entry(near_word(4, 1'b0, 1'b0), 1'b0);
        send_entry(near_word(1, 1'b1, 1'b0), 1'b1);

        // --- directed: random query, every mismatch count, both strands ---
        load_config(rand_word(), 20, 2000);
        send_entry(near_word(0, 1'b0, 1'b0), 1'b0);
        send_entry(near_word(0, 1'b1, 1'b0), 1'b0);   // reverse-complement hit
        send_entry(near_word(1, 1'b0, 1'b0), 1'b0);
        send_entry(near_word(2, 1'b1, 1'b0), 1'b0);
        send_entry(near_word(3, 1'b0, 1'b0), 1'b0);
        send_entry(near_word(4, 1'b1, 1'b0), 1'b0);   // edge of the hit window
        send_entry(near_word(5, 1'b0, 1'b0), 1'b0);   // just outside
        send_entry(near_word(0, 1'b0, 1'b1), 1'b0);   // only high bits differ
        send_entry('0, 1'b0);
        send_entry(near_word(2, 1'b0, 1'b0), 1'b1);

        // --- directed: zero length and zero list limit ---
        load_config(rand_word(), 0, 0);
        send_entry(near_word(0, 1'b0, 1'b0), 1'b0);
        send_entry(near_word(0, 1'b1, 1'b0), 1'b0);
        send_entry(rand_word(), 1'b0);
        send_entry(near_word(0, 1'b0, 1'b1), 1'b1);

        // --- random phases cycling through register extremes ---
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase % 6)
                0: begin len = 31; maxl = 65535; q = '1; end
                1: begin len = 0;  maxl = 0;     q = rand_word(); end
                2: begin len = 1;  maxl = 1;     q = rand_word(); end
                3: begin
                    len  = $urandom_range(2, 30);
                    maxl = $urandom_range(2, 6);
                    q    = rand_word();
                end
                4: begin
                    len  = $urandom_range(1, 31);
                    maxl = $urandom_range(1, 65535);
                    q    = '0;
                end
                default: begin len = 31; maxl = 3; q = rand_word(); end
            endcase
            load_config(q, len, maxl);
            scans = $urandom_range(2, 5);
            for (s = 0; s < scans; s++) begin
                run_scan(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
                // sender holds off mid-phase until the result side catches up
                if ($urandom_range(0, 3) == 0) wait_drain();
            end
            phase++;
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("guide_offtarget_hamming_scan_unit_test: clean");
        end else begin
            $display("guide_offtarget_hamming_scan_unit_test: errors");
        end
        $finish;
    end

endmodule
